// ===== rtl/pcm_channel_downmix_gain_macros.svh =====
// Assertion macros shared by the downmix RTL.
// Needs clk_i and rst_ni in the scope of the module that uses them.
`ifndef PCM_CHANNEL_DOWNMIX_GAIN_MACROS_SVH
`define PCM_CHANNEL_DOWNMIX_GAIN_MACROS_SVH

// a implies b on the same clock edge
`define PCMDMX_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (b)) \
    else $error("implication check failed");

// a implies b on the following clock edge
`define PCMDMX_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (b)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/pcmdmx_pkg.sv =====
// Package for the PCM downmix block: payload types, codes, weights and the
// Q12 truncate-and-saturate helper. No dependencies.
package pcmdmx_pkg;

  localparam int SAMPLE_W = 16;
  localparam int WIDE_W   = 33;  // mix accumulator and gain product
  localparam int GAIN_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int NUM_CH   = 6;
  localparam int Q12_SHIFT    = 12;
  localparam int CENTER_SHIFT = 11;  // weight 0.5 in Q12

  localparam logic signed [WIDE_W-1:0] W_REAR_LFE = 33'sd2867;  // 0.7 in Q12
  localparam logic signed [WIDE_W-1:0] Q12_BIAS   = 33'sd4095;
  localparam logic signed [WIDE_W-1:0] SAT_HI_W   = 33'sd32767;
  localparam logic signed [WIDE_W-1:0] SAT_LO_W   = -33'sd32768;
  localparam logic signed [SAMPLE_W-1:0] SAT_HI_16 = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAT_LO_16 = 16'sh8000;

  localparam logic [GAIN_W-1:0] UNITY_GAIN = 16'd4096;

  localparam logic [2:0] CNT_MONO     = 3'd1;
  localparam logic [2:0] CNT_STEREO   = 3'd2;
  localparam logic [2:0] CNT_SURROUND = 3'd6;

  localparam logic [1:0] MODE_PASS  = 2'd0;
  localparam logic [1:0] MODE_LEFT  = 2'd1;
  localparam logic [1:0] MODE_RIGHT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SURROUND  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEREO    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NORM_ON   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NORM_GAIN = 2'd3;

  typedef struct packed {
    logic [2:0]                 channel_count;
    logic signed [SAMPLE_W-1:0] in_ch0;
    logic signed [SAMPLE_W-1:0] in_ch1;
    logic signed [SAMPLE_W-1:0] in_ch2;
    logic signed [SAMPLE_W-1:0] in_ch3;
    logic signed [SAMPLE_W-1:0] in_ch4;
    logic signed [SAMPLE_W-1:0] in_ch5;
    logic                       frame_last;
  } pcmdmx_in_t;

  typedef struct packed {
    logic [2:0]                 out_count;
    logic signed [SAMPLE_W-1:0] out_ch0;
    logic signed [SAMPLE_W-1:0] out_ch1;
    logic signed [SAMPLE_W-1:0] out_ch2;
    logic signed [SAMPLE_W-1:0] out_ch3;
    logic signed [SAMPLE_W-1:0] out_ch4;
    logic signed [SAMPLE_W-1:0] out_ch5;
    logic                       out_last;
  } pcmdmx_out_t;

  // stage enables handed to each gain lane
  typedef struct packed {
    logic sel_en;
    logic mul_en;
  } pcmdmx_lane_en_t;

  // divide by 4096 toward zero, then clamp to 16 bits
  function automatic logic signed [SAMPLE_W-1:0] q12_trunc_sat(
    input logic signed [WIDE_W-1:0] v
  );
    logic signed [WIDE_W-1:0] bias;
    logic signed [WIDE_W-1:0] t;
    bias = v[WIDE_W-1] ? Q12_BIAS : '0;
    t    = (v + bias) >>> Q12_SHIFT;
    if (t > SAT_HI_W) begin
      return SAT_HI_16;
    end else if (t < SAT_LO_W) begin
      return SAT_LO_16;
    end
    return t[SAMPLE_W-1:0];
  endfunction

endpackage

// ===== rtl/pcm_channel_downmix_gain.sv =====
// PCM channel formatter with 5.1 downmix and Q4.12 gain normalisation.
// One item (frame) is accepted every cycle while out_stall_i stays low; each
// accepted item passes the registers in order (route/mix accumulate, mix
// saturate, gain multiply, output register). Throughput is set by the
// six parallel gain lanes, each holding one 16x17 multiply per stage, so
// a full rate of one item per clock is held. A two-entry output stage
// (register plus skid) decouples the ports, so in_stall_o comes only from
// flops. Frames whose channel_count is not 1, 2 or 6 are consumed and give
// no result. Configuration writes are taken at once (cfg_ready_o is always
// high) and should only be issued while no item is in flight.
// Depends on pcmdmx_pkg, pcmdmx_mix_lane, pcmdmx_gain_lane, pcmdmx_out_skid
// and the assertion macro header.
`include "pcm_channel_downmix_gain_macros.svh"

module pcm_channel_downmix_gain
  import pcmdmx_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // item input
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  pcmdmx_in_t           in_data_i,
  // item output
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output pcmdmx_out_t          out_data_o,
  // register writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [GAIN_W-1:0]    cfg_data_i
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic              surround_q;
  logic [1:0]        stereo_mode_q;
  logic              norm_on_q;
  logic [GAIN_W-1:0] norm_gain_q;
  logic [GAIN_W-1:0] gain_eff;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      surround_q    <= 1'b1;
      stereo_mode_q <= MODE_PASS;
      norm_on_q     <= 1'b0;
      norm_gain_q   <= UNITY_GAIN;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_SURROUND:  surround_q    <= cfg_data_i[0];
        CFG_STEREO:    stereo_mode_q <= cfg_data_i[1:0];
        CFG_NORM_ON:   norm_on_q     <= cfg_data_i[0];
        CFG_NORM_GAIN: norm_gain_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // unity gain reproduces the sample exactly, so bypass is just gain 4096
  assign gain_eff = norm_on_q ? norm_gain_q : UNITY_GAIN;

  // ---------------------------------------------------------------------
  // Pipeline control: stage enables chain back from the output stage
  // ---------------------------------------------------------------------
  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;
  logic out_ready;
  logic push;
  logic accept;
  logic cnt_ok;

  assign en3        = !v3_q || out_ready;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign push       = v3_q && out_ready;
  assign in_stall_o = !en1;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= accept && cnt_ok;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: decode channel count and route samples to the lanes
  // ---------------------------------------------------------------------
  logic signed [SAMPLE_W-1:0] raw_d [NUM_CH];
  logic signed [SAMPLE_W-1:0] raw_q [NUM_CH];
  logic mix_d, six_d;
  logic mix_q, six1_q, last1_q;
  logic six2_q, last2_q;
  logic six3_q, last3_q;

  always_comb begin
    raw_d  = '{default: '0};
    mix_d  = 1'b0;
    six_d  = 1'b0;
    cnt_ok = 1'b1;
    unique case (in_data_i.channel_count)
      CNT_MONO: begin
        raw_d[0] = in_data_i.in_ch0;
        raw_d[1] = in_data_i.in_ch0;
      end
      CNT_STEREO: begin
        case (stereo_mode_q)
          MODE_PASS: begin
            raw_d[0] = in_data_i.in_ch0;
            raw_d[1] = in_data_i.in_ch1;
          end
          MODE_LEFT: begin
            raw_d[0] = in_data_i.in_ch0;
            raw_d[1] = in_data_i.in_ch0;
          end
          default: begin  // right to both, also for the unused code
            raw_d[0] = in_data_i.in_ch1;
            raw_d[1] = in_data_i.in_ch1;
          end
        endcase
      end
      CNT_SURROUND: begin
        if (surround_q) begin
          mix_d = 1'b1;
        end else begin
          // FL FR FC LFE BL BR
          six_d    = 1'b1;
          raw_d[0] = in_data_i.in_ch1;
          raw_d[1] = in_data_i.in_ch2;
          raw_d[2] = in_data_i.in_ch0;
          raw_d[3] = in_data_i.in_ch5;
          raw_d[4] = in_data_i.in_ch3;
          raw_d[5] = in_data_i.in_ch4;
        end
      end
      default: cnt_ok = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      raw_q   <= raw_d;
      mix_q   <= mix_d;
      six1_q  <= six_d;
      last1_q <= in_data_i.frame_last;
    end
    if (en2) begin
      six2_q  <= six1_q;
      last2_q <= last1_q;
    end
    if (en3) begin
      six3_q  <= six2_q;
      last3_q <= last2_q;
    end
  end

  // mix lanes: left from FL/RL, right from FR/RR, both with centre and LFE
  logic signed [WIDE_W-1:0] acc_l, acc_r;

  pcmdmx_mix_lane u_mix_l (
    .clk_i    (clk_i),
    .en_i     (en1),
    .front_i  (in_data_i.in_ch1),
    .rear_i   (in_data_i.in_ch3),
    .center_i (in_data_i.in_ch0),
    .lfe_i    (in_data_i.in_ch5),
    .acc_o    (acc_l)
  );

  pcmdmx_mix_lane u_mix_r (
    .clk_i    (clk_i),
    .en_i     (en1),
    .front_i  (in_data_i.in_ch2),
    .rear_i   (in_data_i.in_ch4),
    .center_i (in_data_i.in_ch0),
    .lfe_i    (in_data_i.in_ch5),
    .acc_o    (acc_r)
  );

  // ---------------------------------------------------------------------
  // Stages 2 and 3: six gain lanes
  // ---------------------------------------------------------------------
  logic signed [WIDE_W-1:0]   lane_acc [NUM_CH];
  logic                       lane_use [NUM_CH];
  logic signed [SAMPLE_W-1:0] lane_y   [NUM_CH];
  pcmdmx_lane_en_t            lane_en;

  always_comb begin
    lane_acc    = '{default: '0};
    lane_use    = '{default: 1'b0};
    lane_acc[0] = acc_l;
    lane_acc[1] = acc_r;
    lane_use[0] = mix_q;
    lane_use[1] = mix_q;
    lane_en.sel_en = en2;
    lane_en.mul_en = en3;
  end

  for (genvar i = 0; i < NUM_CH; i++) begin : g_lane
    pcmdmx_gain_lane u_gain (
      .clk_i     (clk_i),
      .en_i      (lane_en),
      .raw_i     (raw_q[i]),
      .acc_i     (lane_acc[i]),
      .use_acc_i (lane_use[i]),
      .gain_i    (gain_eff),
      .y_o       (lane_y[i])
    );
  end

  // ---------------------------------------------------------------------
  // Merge lane results into one output item
  // ---------------------------------------------------------------------
  pcmdmx_out_t merged;

  always_comb begin
    merged.out_count = six3_q ? CNT_SURROUND : CNT_STEREO;
    merged.out_ch0   = lane_y[0];
    merged.out_ch1   = lane_y[1];
    merged.out_ch2   = lane_y[2];
    merged.out_ch3   = lane_y[3];
    merged.out_ch4   = lane_y[4];
    merged.out_ch5   = lane_y[5];
    merged.out_last  = last3_q;
  end

  pcmdmx_out_skid u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .data_i      (merged),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  `PCMDMX_ASSERT_IMP(a_out_count_legal, out_valid_o,
                     out_data_o.out_count == CNT_STEREO ||
                     out_data_o.out_count == CNT_SURROUND)
  `PCMDMX_ASSERT_IMP(a_stereo_tail_zero,
                     out_valid_o && out_data_o.out_count == CNT_STEREO,
                     out_data_o.out_ch2 == '0 && out_data_o.out_ch3 == '0 &&
                     out_data_o.out_ch4 == '0 && out_data_o.out_ch5 == '0)
  `PCMDMX_ASSERT_IMP(a_stall_only_when_full, in_stall_o, v1_q && v2_q && v3_q)

endmodule

// ===== rtl/pcmdmx_mix_lane.sv =====
// One side of the 5.1 stereo mix: registered Q12 weighted sum.
// Depends on pcmdmx_pkg.
module pcmdmx_mix_lane
  import pcmdmx_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic signed [SAMPLE_W-1:0] front_i,
  input  logic signed [SAMPLE_W-1:0] rear_i,
  input  logic signed [SAMPLE_W-1:0] center_i,
  input  logic signed [SAMPLE_W-1:0] lfe_i,
  output logic signed [WIDE_W-1:0]   acc_o
);

  logic signed [SAMPLE_W:0]   rl_sum;
  logic signed [WIDE_W-1:0]   acc_d;
  logic signed [WIDE_W-1:0]   acc_q;

  // rear and LFE share the 0.7 weight, so one multiply covers both
  always_comb begin
    rl_sum = (SAMPLE_W+1)'(rear_i) + (SAMPLE_W+1)'(lfe_i);
    acc_d  = (WIDE_W'(front_i) <<< Q12_SHIFT)
           + (WIDE_W'(center_i) <<< CENTER_SHIFT)
           + WIDE_W'(rl_sum) * W_REAR_LFE;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

// ===== rtl/pcmdmx_gain_lane.sv =====
// One output channel: picks mix or routed sample, applies Q4.12 gain,
// truncates and saturates. Depends on pcmdmx_pkg.
module pcmdmx_gain_lane
  import pcmdmx_pkg::*;
(
  input  logic                       clk_i,
  input  pcmdmx_lane_en_t            en_i,
  input  logic signed [SAMPLE_W-1:0] raw_i,
  input  logic signed [WIDE_W-1:0]   acc_i,
  input  logic                       use_acc_i,
  input  logic [GAIN_W-1:0]          gain_i,
  output logic signed [SAMPLE_W-1:0] y_o
);

  logic signed [SAMPLE_W-1:0] x_d;
  logic signed [SAMPLE_W-1:0] x_q;
  logic signed [GAIN_W:0]     g_s;
  logic signed [WIDE_W-1:0]   prod_d;
  logic signed [WIDE_W-1:0]   prod_q;

  always_comb begin
    x_d    = use_acc_i ? q12_trunc_sat(acc_i) : raw_i;
    g_s    = {1'b0, gain_i};
    prod_d = WIDE_W'(x_q) * WIDE_W'(g_s);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.sel_en) begin
      x_q <= x_d;
    end
    if (en_i.mul_en) begin
      prod_q <= prod_d;
    end
  end

  assign y_o = q12_trunc_sat(prod_q);

endmodule

// ===== rtl/pcmdmx_out_skid.sv =====
// Output register plus skid entry holding the merged lane results as one item.
// Depends on pcmdmx_pkg and the assertion macro header.
`include "pcm_channel_downmix_gain_macros.svh"

module pcmdmx_out_skid
  import pcmdmx_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  pcmdmx_out_t data_i,
  output logic        ready_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output pcmdmx_out_t out_data_o
);

  logic        out_v_q, out_v_d;
  logic        sk_v_q, sk_v_d;
  pcmdmx_out_t out_q, out_d;
  pcmdmx_out_t sk_q, sk_d;

  always_comb begin
    out_v_d = out_v_q;
    sk_v_d  = sk_v_q;
    out_d   = out_q;
    sk_d    = sk_q;
    if (!out_v_q || !out_stall_i) begin
      if (sk_v_q) begin
        out_v_d = 1'b1;
        out_d   = sk_q;
        sk_v_d  = 1'b0;
      end else begin
        out_v_d = push_i;
        out_d   = data_i;
      end
    end else if (push_i) begin
      sk_v_d = 1'b1;
      sk_d   = data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      sk_v_q  <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
      sk_v_q  <= sk_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    sk_q  <= sk_d;
  end

  assign ready_o     = !sk_v_q;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  `PCMDMX_ASSERT_IMP(a_skid_behind_out, sk_v_q, out_v_q)
  `PCMDMX_ASSERT_NXT(a_skid_keeps_item, sk_v_q && out_stall_i, sk_v_q)

endmodule
